// ----- src/srt_pkg.sv -----
// srt_pkg: shared types, codes and defaults of the space-time reservation table
// used by every module of the block; depends on nothing
`default_nettype none

package srt_pkg;

  localparam int LOCATIONS_DEF = 256;
  localparam int HORIZON_DEF   = 256;
  localparam int AGENTS_DEF    = 256;
  localparam int MAX_PATH_DEF  = 256;

  localparam int OWN_W = 9;
  localparam logic [OWN_W-1:0] FREE_OWNER = 9'd256;
  localparam logic [8:0] NO_GOAL = 9'd511;

  typedef enum logic [2:0] {
    OP_RESERVE  = 3'd0,
    OP_VALIDATE = 3'd1,
    OP_RELEASE  = 3'd2,
    OP_PURGE    = 3'd3,
    OP_QUERY    = 3'd4,
    OP_HOLD     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_INCONS   = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_VERTEX = 2'd1,
    K_EDGE   = 2'd2,
    K_TARGET = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EVAL, S_QPREV, S_QFROM, S_HOLD_RD, S_HOLD_CK,
    S_RB_RD, S_RB_WR, S_PURGE_RD, S_PURGE_WR, S_SPAN_RD, S_SPAN_CK, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    U_NOP, U_CLEAR, U_CAPTURE, U_EVAL, U_QPREV, U_QFROM, U_HOLD_RD, U_HOLD_CK,
    U_RB_RD, U_RB_WR, U_PURGE_RD, U_PURGE_WR, U_SPAN_RD, U_SPAN_CK, U_DONE
  } uop_t;

  typedef enum logic [2:0] {
    N_DONE, N_RB, N_PURGE, N_SPAN, N_QPREV, N_HOLD
  } nxt_t;

  typedef struct packed {
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    nxt_t nxt;
    logic cells_last;
    logic locs_last;
    logic ucount_zero;
    logic hold_stop;
    logic cell_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- src/srt_ctrl.sv -----
// srt_ctrl: sequencer of the reservation table, clearing pass, per-op walks
// and result handoff; depends on srt_pkg
`default_nettype none

module srt_ctrl
  import srt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.uop == U_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd.uop    = U_NOP;
    in_ready   = (state == S_IDLE);
    case (state)
      S_CLEAR: begin
        cmd.uop = U_CLEAR;
        if (sts.cells_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.uop    = U_CAPTURE;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.uop = U_EVAL;
        case (sts.nxt)
          N_RB:    state_next = S_RB_RD;
          N_PURGE: state_next = S_PURGE_RD;
          N_SPAN:  state_next = S_SPAN_RD;
          N_QPREV: state_next = S_QPREV;
          N_HOLD:  state_next = S_HOLD_RD;
          default: state_next = S_DONE;
        endcase
      end
      S_QPREV: begin
        cmd.uop    = U_QPREV;
        state_next = S_QFROM;
      end
      S_QFROM: begin
        cmd.uop    = U_QFROM;
        state_next = S_DONE;
      end
      S_HOLD_RD: begin
        if (sts.hold_stop) begin
          state_next = S_DONE;
        end else begin
          cmd.uop    = U_HOLD_RD;
          state_next = S_HOLD_CK;
        end
      end
      S_HOLD_CK: begin
        cmd.uop    = U_HOLD_CK;
        state_next = sts.cell_free ? S_HOLD_RD : S_DONE;
      end
      S_RB_RD: begin
        if (sts.ucount_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.uop    = U_RB_RD;
          state_next = S_RB_WR;
        end
      end
      S_RB_WR: begin
        cmd.uop    = U_RB_WR;
        state_next = S_RB_RD;
      end
      S_PURGE_RD: begin
        cmd.uop    = U_PURGE_RD;
        state_next = S_PURGE_WR;
      end
      S_PURGE_WR: begin
        cmd.uop    = U_PURGE_WR;
        state_next = sts.cells_last ? S_DONE : S_PURGE_RD;
      end
      S_SPAN_RD: begin
        cmd.uop    = U_SPAN_RD;
        state_next = S_SPAN_CK;
      end
      S_SPAN_CK: begin
        cmd.uop    = U_SPAN_CK;
        state_next = sts.locs_last ? S_DONE : S_SPAN_RD;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.uop    = U_DONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/srt_datapath.sv -----
// srt_datapath: cell, goal and undo memories, span and undo state, op decisions
// and result registers; depends on srt_pkg
`default_nettype none

module srt_datapath
  import srt_pkg::*;
#(
  parameter int LOCATIONS = LOCATIONS_DEF,
  parameter int HORIZON   = HORIZON_DEF,
  parameter int AGENTS    = AGENTS_DEF,
  parameter int MAX_PATH  = MAX_PATH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic [39:0] in_tdata,
  input  wire logic [2:0]  in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  output logic      [39:0] out_tdata,
  output logic      [3:0]  out_tuser
);

  localparam longint unsigned CELLS = longint'(LOCATIONS) * longint'(HORIZON);
  localparam int AW = $clog2(CELLS);
  localparam int GW = $clog2(LOCATIONS);
  localparam int UW = $clog2(MAX_PATH);
  localparam int CW = $clog2(MAX_PATH + 1);
  localparam int HW = $clog2(HORIZON + 1);

  function automatic logic [AW-1:0] caddr(input logic [7:0] l, input logic [HW-1:0] tt);
    return AW'(AW'(l) * AW'(HORIZON) + AW'(tt));
  endfunction

  logic [2:0] op_r;
  logic [7:0] agent_r, loc_r, from_r, t_r;
  logic       cont_r, last_r, wait_r;

  logic [8:0] cell_mem [CELLS];
  logic [8:0] cell_q, cell_wd;
  logic [AW-1:0] cell_ra, cell_wa;
  logic cell_re, cell_we;

  logic [8:0] goal_mem [LOCATIONS];
  logic [8:0] goal_q, goal_wd;
  logic [GW-1:0] goal_ra, goal_wa;
  logic goal_re, goal_we;

  logic [AW-1:0] undo_addr_mem [MAX_PATH];
  logic [8:0]    undo_prev_mem [MAX_PATH];
  logic [AW-1:0] undo_aq;
  logic [8:0]    undo_pq;
  logic undo_re, undo_we;

  logic [7:0]    span;
  logic [CW-1:0] ucount;
  logic          aborted, table_enable;
  logic [AW-1:0] idx;
  logic [8:0]    m_r, m_next, prev_r, occ_r;
  logic [7:0]    span_sat, at_r;
  logic [HW-1:0] hold_r;
  logic [1:0]    st_r, kind_r;

  logic loc_ok, from_ok, t_ok, ag_ok, step_ok, good, ufull, cell_free;
  logic [8:0] agent_own;
  logic [AW-1:0] step_addr;

  status_t    ev_st;
  kind_t      ev_kind;
  logic [8:0] ev_occ, ev_cell_wd, ev_goal_wd;
  logic [7:0] ev_at;
  logic [HW-1:0] ev_hold;
  nxt_t       ev_nxt;
  logic ev_cell_we, ev_goal_we, ev_span_we, ev_abort_we, ev_abort_d, ev_undo_we, ev_uc_we;
  logic [CW-1:0] ev_uc_d;

  assign loc_ok    = 32'(loc_r) < LOCATIONS;
  assign from_ok   = 32'(from_r) < LOCATIONS;
  assign t_ok      = 32'(t_r) < HORIZON;
  assign ag_ok     = 32'(agent_r) < AGENTS;
  assign step_ok   = loc_ok && t_ok && ag_ok;
  assign agent_own = {1'b0, agent_r};
  assign cell_free = (cell_q == FREE_OWNER);
  assign good      = cont_r ? (cell_q == agent_own) : cell_free;
  assign ufull     = (ucount == CW'(MAX_PATH));
  assign step_addr = caddr(loc_r, HW'(t_r));
  assign m_next    = (goal_q != NO_GOAL && goal_q > m_r) ? goal_q : m_r;
  assign span_sat  = (m_next > 9'd255) ? 8'hFF : m_next[7:0];

  assign sts.nxt         = ev_nxt;
  assign sts.cells_last  = (idx == AW'(CELLS - 1));
  assign sts.locs_last   = (idx == AW'(LOCATIONS - 1));
  assign sts.ucount_zero = (ucount == '0);
  assign sts.hold_stop   = (hold_r <= HW'(t_r));
  assign sts.cell_free   = cell_free;

  always_comb begin
    ev_st       = ST_OK;
    ev_kind     = K_NONE;
    ev_occ      = FREE_OWNER;
    ev_at       = '0;
    ev_hold     = '0;
    ev_nxt      = N_DONE;
    ev_cell_we  = 1'b0;
    ev_cell_wd  = agent_own;
    ev_goal_we  = 1'b0;
    ev_goal_wd  = NO_GOAL;
    ev_span_we  = 1'b0;
    ev_abort_we = 1'b0;
    ev_abort_d  = !last_r;
    ev_undo_we  = 1'b0;
    ev_uc_we    = 1'b0;
    ev_uc_d     = last_r ? '0 : ucount + CW'(1);
    case (op_t'(op_r))
      OP_RESERVE: begin
        if (!table_enable || !step_ok) begin
          ev_st = ST_IGNORED;
        end else if (!good || (last_r && wait_r && goal_q != NO_GOAL)) begin
          ev_st = ST_INCONS;
        end else begin
          ev_cell_we = 1'b1;
          if (last_r) begin
            ev_goal_we = wait_r;
            ev_goal_wd = {1'b0, t_r};
            ev_span_we = (t_r > span);
          end
        end
      end
      OP_VALIDATE: begin
        if (!table_enable) begin
          ev_st = ST_IGNORED;
        end else if (aborted) begin
          ev_st       = ST_IGNORED;
          ev_abort_we = last_r;
          ev_abort_d  = 1'b0;
        end else if (!step_ok) begin
          ev_st       = ST_IGNORED;
          ev_nxt      = N_RB;
          ev_abort_we = 1'b1;
        end else if (!good) begin
          ev_nxt      = N_RB;
          ev_abort_we = 1'b1;
          if (cont_r && cell_free) begin
            ev_st = ST_INCONS;
          end else begin
            ev_st  = ST_CONFLICT;
            ev_occ = cell_q;
            ev_at  = t_r;
          end
        end else if (ufull) begin
          ev_st       = ST_INCONS;
          ev_nxt      = N_RB;
          ev_abort_we = 1'b1;
        end else begin
          ev_cell_we = 1'b1;
          ev_undo_we = 1'b1;
          ev_uc_we   = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (!table_enable || !step_ok) begin
          ev_st = ST_IGNORED;
        end else if (!cont_r && cell_q != agent_own) begin
          ev_st = ST_INCONS;
        end else begin
          ev_cell_we = !cont_r;
          ev_cell_wd = FREE_OWNER;
          if (last_r) begin
            ev_goal_we = wait_r;
            if (span == t_r) ev_nxt = N_SPAN;
          end
        end
      end
      OP_PURGE: begin
        if (!table_enable || !loc_ok || !ag_ok) begin
          ev_st = ST_IGNORED;
        end else begin
          ev_goal_we = 1'b1;
          ev_nxt     = N_PURGE;
        end
      end
      OP_QUERY: begin
        if (!loc_ok || !from_ok || !t_ok) begin
          ev_st = ST_IGNORED;
        end else if (!cell_free) begin
          ev_st   = ST_CONFLICT;
          ev_kind = K_VERTEX;
        end else if (t_r != 8'd0) begin
          ev_nxt = N_QPREV;
        end else if (goal_q <= {1'b0, t_r}) begin
          ev_st   = ST_CONFLICT;
          ev_kind = K_TARGET;
        end
      end
      OP_HOLD: begin
        if (!loc_ok || !t_ok) begin
          ev_st   = ST_IGNORED;
          ev_hold = HW'(t_r);
        end else begin
          ev_hold = HW'(HORIZON);
          ev_nxt  = N_HOLD;
        end
      end
      default: ev_st = ST_IGNORED;
    endcase
  end

  always_comb begin
    cell_re = 1'b0;
    cell_ra = step_addr;
    cell_we = 1'b0;
    cell_wa = step_addr;
    cell_wd = FREE_OWNER;
    goal_re = 1'b0;
    goal_ra = GW'(loc_r);
    goal_we = 1'b0;
    goal_wa = GW'(loc_r);
    goal_wd = NO_GOAL;
    undo_re = 1'b0;
    undo_we = 1'b0;
    case (cmd.uop)
      U_CLEAR: begin
        cell_we = 1'b1;
        cell_wa = idx;
        goal_we = 64'(idx) < 64'(LOCATIONS);
        goal_wa = GW'(idx);
      end
      U_CAPTURE: begin
        cell_re = 1'b1;
        cell_ra = caddr(in_tdata[15:8], HW'(in_tdata[31:24]));
        goal_re = 1'b1;
        goal_ra = GW'(in_tdata[15:8]);
      end
      U_EVAL: begin
        cell_re = 1'b1;
        cell_ra = caddr(loc_r, HW'(t_r) - HW'(1));
        cell_we = ev_cell_we;
        cell_wd = ev_cell_wd;
        goal_we = ev_goal_we;
        goal_wd = ev_goal_wd;
        undo_we = ev_undo_we;
      end
      U_QPREV: begin
        cell_re = 1'b1;
        cell_ra = caddr(from_r, HW'(t_r));
      end
      U_HOLD_RD: begin
        cell_re = 1'b1;
        cell_ra = caddr(loc_r, hold_r - HW'(1));
      end
      U_RB_RD: undo_re = 1'b1;
      U_RB_WR: begin
        cell_we = 1'b1;
        cell_wa = undo_aq;
        cell_wd = undo_pq;
      end
      U_PURGE_RD: begin
        cell_re = 1'b1;
        cell_ra = idx;
      end
      U_PURGE_WR: begin
        cell_we = (cell_q == agent_own);
        cell_wa = idx;
      end
      U_SPAN_RD: begin
        goal_re = 1'b1;
        goal_ra = GW'(idx);
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    if (cell_re) cell_q <= cell_mem[cell_ra];
  end

  always_ff @(posedge clk) begin
    if (goal_we) goal_mem[goal_wa] <= goal_wd;
    if (goal_re) goal_q <= goal_mem[goal_ra];
  end

  always_ff @(posedge clk) begin
    if (undo_we) begin
      undo_addr_mem[ucount[UW-1:0]] <= step_addr;
      undo_prev_mem[ucount[UW-1:0]] <= cell_q;
    end
    if (undo_re) begin
      undo_aq <= undo_addr_mem[UW'(ucount - CW'(1))];
      undo_pq <= undo_prev_mem[UW'(ucount - CW'(1))];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      span         <= '0;
      ucount       <= '0;
      aborted      <= 1'b0;
      table_enable <= 1'b1;
      idx          <= '0;
    end else begin
      if (cfg_we) table_enable <= cfg_data;
      case (cmd.uop)
        U_CLEAR:    idx <= idx + AW'(1);
        U_EVAL: begin
          idx <= '0;
          if (ev_span_we) span <= t_r;
          if (ev_abort_we) aborted <= ev_abort_d;
          if (ev_uc_we) ucount <= ev_uc_d;
        end
        U_RB_RD:    ucount <= ucount - CW'(1);
        U_PURGE_WR: idx <= idx + AW'(1);
        U_SPAN_CK: begin
          idx <= idx + AW'(1);
          if (sts.locs_last) span <= span_sat;
        end
        default: ;
      endcase
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    case (cmd.uop)
      U_CAPTURE: begin
        op_r    <= in_tuser;
        agent_r <= in_tdata[7:0];
        loc_r   <= in_tdata[15:8];
        from_r  <= in_tdata[23:16];
        t_r     <= in_tdata[31:24];
        cont_r  <= in_tdata[32];
        wait_r  <= in_tdata[33];
        last_r  <= in_tlast;
      end
      U_EVAL: begin
        st_r   <= ev_st;
        kind_r <= ev_kind;
        occ_r  <= ev_occ;
        at_r   <= ev_at;
        hold_r <= ev_hold;
        m_r    <= '0;
      end
      U_QPREV: prev_r <= cell_q;
      U_QFROM: begin
        if (prev_r != FREE_OWNER && cell_q == prev_r) begin
          st_r   <= ST_CONFLICT;
          kind_r <= K_EDGE;
        end else if (goal_q <= {1'b0, t_r}) begin
          st_r   <= ST_CONFLICT;
          kind_r <= K_TARGET;
        end
      end
      U_HOLD_CK: if (cell_free) hold_r <= hold_r - HW'(1);
      U_SPAN_CK: m_r <= m_next;
      U_DONE: begin
        out_tdata <= {6'd0, span, 9'(hold_r), at_r, occ_r};
        out_tuser <= {kind_r, st_r};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/space_time_reservation_table_unit.sv -----
// space_time_reservation_table_unit: top level, sequencer plus datapath
// steps: each input word is captured, evaluated and its result loaded; a query edge check
// also reads the previous and from cells, holding time checks one time after another,
// rollback rewrites each logged step, purge each cell, makespan recompute reads each location
// input: one word at a time, next input word taken in the cycle after the result is loaded
// reset: a clearing pass frees all cells and goals, no input meanwhile
`default_nettype none

module space_time_reservation_table_unit
  import srt_pkg::*;
#(
  parameter int LOCATIONS = LOCATIONS_DEF,
  parameter int HORIZON   = HORIZON_DEF,
  parameter int AGENTS    = AGENTS_DEF,
  parameter int MAX_PATH  = MAX_PATH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // agent[7:0], location[15:8], from_location[23:16], time_req[31:24],
  // continues_task[32], wait_at_goal[33]
  input  wire logic [39:0] s_axis_tdata,
  // opcode[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  // last_step
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // occupant[8:0], at_time[16:9], holding_time[25:17], makespan[33:26]
  output logic      [39:0] m_axis_tdata,
  // status[1:0], conflict_kind[3:2]
  output logic      [3:0]  m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srt_datapath #(
    .LOCATIONS (LOCATIONS),
    .HORIZON   (HORIZON),
    .AGENTS    (AGENTS),
    .MAX_PATH  (MAX_PATH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (s_axis_tdata),
    .in_tuser  (s_axis_tuser),
    .in_tlast  (s_axis_tlast),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data[0]),
    .out_tdata (m_axis_tdata),
    .out_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- src/srt_checker.sv -----
// srt_checker: port-level assertions for the reservation table, bound to the top
// depends on srt_pkg and space_time_reservation_table_unit
`default_nettype none

module srt_checker
  import srt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [3:0]  m_axis_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word shown after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_kind_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3:2] != K_NONE |-> m_axis_tuser[1:0] == ST_CONFLICT)
    else $error("conflict kind without conflict status");

  a_occ_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[8:0] != FREE_OWNER |-> m_axis_tuser[1:0] == ST_CONFLICT
      && m_axis_tuser[3:2] == K_NONE)
    else $error("occupant reported without validate conflict");

endmodule

bind space_time_reservation_table_unit srt_checker u_srt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
